// ===== hdl/kss_pkg.sv =====
// shared types and constants for the kuramoto-sakaguchi derivative unit
`timescale 1ns / 1ps
package kss_pkg;

	typedef struct packed {
		logic [15:0] phase;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] derivative;
		logic [5:0]         oscillator_index;
		logic               last_result;
	} out_item_t;

	typedef enum logic [1:0] {
		REG_NATURAL_FREQUENCY = 2'd0,
		REG_COUPLING          = 2'd1,
		REG_COS_LAG           = 2'd2,
		REG_SIN_LAG           = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SC,
		ST_RD,
		ST_ST,
		ST_DW,
		ST_EMIT
	} state_t;

	localparam logic signed [23:0] RST_NATURAL_FREQUENCY = 24'sd32768;
	localparam logic signed [15:0] RST_COUPLING          = 16'sd131;
	localparam logic signed [15:0] RST_COS_LAG           = -16'sd16384;
	localparam logic signed [15:0] RST_SIN_LAG           = 16'sd28378;

	localparam logic [15:0] POLY_A = 16'd51472;
	localparam logic [15:0] POLY_B = 16'd21024;
	localparam logic [15:0] POLY_C = 16'd2320;

	localparam logic signed [21:0] SUM_HI = 22'sd2097151;
	localparam logic signed [21:0] SUM_LO = -22'sd2097152;
	localparam logic signed [23:0] OUT_HI = 24'sd8388607;
	localparam logic signed [23:0] OUT_LO = -24'sd8388608;

endpackage

// ===== hdl/kss_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module kss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/kss_sincos.sv =====
// iterative polynomial sine and cosine of a phase on one shared multiplier
`timescale 1ns / 1ps
module kss_sincos (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        phase,
	output logic               done,
	output logic signed [15:0] sine,
	output logic signed [15:0] cosine
);

	logic        busy_q;
	logic [1:0]  step_q;
	logic        cos_q;
	logic [15:0] p_q;
	logic [15:0] x2_q;
	logic [15:0] t_q;
	logic        done_q;
	logic signed [15:0] sine_q;
	logic signed [15:0] cosine_q;

	logic [15:0] pa;
	logic [14:0] u;
	logic [15:0] x;
	logic [15:0] op_a;
	logic [15:0] op_b;
	logic [31:0] prod;
	logic [15:0] res;
	logic [15:0] mag;
	logic signed [15:0] val;

	always_comb begin
		// cosine is the sine a quarter turn on
		pa = cos_q ? p_q + 16'd16384 : p_q;
		u = pa[14] ? 15'd16384 - {1'b0, pa[13:0]} : {1'b0, pa[13:0]};
		x = {u, 1'b0};
		case (step_q)
			2'd0: begin
				op_a = x;
				op_b = x;
			end
			2'd1: begin
				op_a = kss_pkg::POLY_C;
				op_b = x2_q;
			end
			2'd2: begin
				op_a = kss_pkg::POLY_B - t_q;
				op_b = x2_q;
			end
			default: begin
				op_a = kss_pkg::POLY_A - t_q;
				op_b = x;
			end
		endcase
		prod = op_a * op_b;
		res = prod[30:15];
		mag = (res > 16'd32767) ? 16'd32767 : res;
		val = pa[15] ? -$signed(mag) : $signed(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			cos_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
				cos_q  <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					cos_q <= 1'b1;
					if (cos_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			p_q <= phase;
		end
		if (busy_q) begin
			case (step_q)
				2'd0: x2_q <= res;
				2'd1, 2'd2: t_q <= res;
				default: begin
					if (cos_q) begin
						cosine_q <= val;
					end else begin
						sine_q <= val;
					end
				end
			endcase
		end
	end

	assign done   = done_q;
	assign sine   = sine_q;
	assign cosine = cosine_q;

endmodule

// ===== hdl/kss_deriv.sv =====
// pipelined derivative datapath for one stored sine and cosine pair
`timescale 1ns / 1ps
module kss_deriv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] sine,
	input  logic signed [15:0] cosine,
	input  logic signed [21:0] sum_sine,
	input  logic signed [21:0] sum_cosine,
	input  logic signed [15:0] cos_lag,
	input  logic signed [15:0] sin_lag,
	input  logic signed [15:0] coupling,
	input  logic signed [23:0] omega,
	output logic               done,
	output logic signed [23:0] derivative
);

	localparam logic signed [56:0] RND13 = 57'sd4096;
	localparam logic signed [60:0] RND31 = 61'sd1073741824;

	logic [6:0] v_q;

	logic signed [31:0] ccl_s1, ssl_s1, scl_s1, csl_s1;
	logic signed [32:0] a_s2, b_s2;
	logic signed [54:0] pa_s3, pb_s3;
	logic signed [55:0] prod_s4;
	logic signed [43:0] p32_s5;
	logic signed [59:0] pk_s6;
	logic signed [23:0] out_s7;

	logic signed [56:0] rnd_a;
	logic signed [60:0] rnd_b;
	logic signed [29:0] d;
	logic signed [30:0] tot;
	logic signed [23:0] sat_v;

	always_comb begin
		rnd_a = 57'(prod_s4) + RND13;
		rnd_b = 61'(pk_s6) + RND31;
		d = 30'(rnd_b >>> 31);
		tot = 31'(omega) + 31'(d);
		if (tot > 31'(kss_pkg::OUT_HI)) begin
			sat_v = kss_pkg::OUT_HI;
		end else if (tot < 31'(kss_pkg::OUT_LO)) begin
			sat_v = kss_pkg::OUT_LO;
		end else begin
			sat_v = 24'(tot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[5:0], start};
		end
	end

	always_ff @(posedge clk) begin
		ccl_s1  <= 32'(cosine) * 32'(cos_lag);
		ssl_s1  <= 32'(sine) * 32'(sin_lag);
		scl_s1  <= 32'(sine) * 32'(cos_lag);
		csl_s1  <= 32'(cosine) * 32'(sin_lag);
		a_s2    <= 33'(ccl_s1) + 33'(ssl_s1);
		b_s2    <= 33'(scl_s1) - 33'(csl_s1);
		pa_s3   <= 55'(sum_sine) * 55'(a_s2);
		pb_s3   <= 55'(sum_cosine) * 55'(b_s2);
		prod_s4 <= 56'(pa_s3) - 56'(pb_s3);
		p32_s5  <= 44'(rnd_a >>> 13);
		pk_s6   <= 60'(p32_s5) * 60'(coupling);
		out_s7  <= sat_v;
	end

	assign done       = v_q[6];
	assign derivative = out_s7;

endmodule

// ===== hdl/kuramoto_sakaguchi_derivative_unit.sv =====
// top level of the kuramoto-sakaguchi phase-rate unit
`timescale 1ns / 1ps
// Phases are loaded one request at a time; each goes through the
// shared multiplier that forms sine then cosine in four steps each, after
// which the pair goes into the ram and the running sums. A request with last
// set starts the output: one derivative per loaded oscillator in load order,
// each read from the ram and passed through the seven-stage derivative datapath,
// and held until it is taken. Input is stalled during output.
// No clearing pass is needed after reset.
module kuramoto_sakaguchi_derivative_unit #(
	parameter int MAX_OSCILLATORS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  kss_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output kss_pkg::out_item_t out_data
);

	localparam int AW = $clog2(MAX_OSCILLATORS);
	localparam int CW = $clog2(MAX_OSCILLATORS + 1);

	kss_pkg::state_t state_q, state_d;

	logic signed [23:0] omega_q;
	logic signed [15:0] coupling_q, cos_lag_q, sin_lag_q;
	logic signed [21:0] sum_s_q, sum_c_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] i_q;
	logic          last_q;
	kss_pkg::out_item_t out_q;

	logic in_acc, out_acc, full, final_i;
	logic sc_start, sc_done, d_start, d_done;
	logic signed [15:0] sc_sine, sc_cosine;
	logic signed [23:0] d_value;
	logic [31:0] rdata;
	logic signed [22:0] ns_s, ns_c;
	logic [AW+5:0] idx_ext;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign full     = count_q == CW'(MAX_OSCILLATORS);
	assign final_i  = (CW'(i_q) + CW'(1)) == count_q;
	assign sc_start = in_acc && !full;
	assign d_start  = state_q == kss_pkg::ST_ST;
	assign in_stall = state_q != kss_pkg::ST_IDLE;
	assign out_valid = state_q == kss_pkg::ST_EMIT;
	assign out_data = out_q;
	assign ns_s = 23'(sum_s_q) + 23'(sc_sine);
	assign ns_c = 23'(sum_c_q) + 23'(sc_cosine);
	assign idx_ext = {6'd0, i_q};

	kss_sincos u_sincos (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.phase  (in_data.phase),
		.done   (sc_done),
		.sine   (sc_sine),
		.cosine (sc_cosine)
	);

	kss_ram #(
		.WIDTH (32),
		.DEPTH (MAX_OSCILLATORS)
	) u_ram (
		.clk   (clk),
		.we    (sc_done),
		.waddr (count_q[AW-1:0]),
		.wdata ({sc_sine, sc_cosine}),
		.raddr (i_q),
		.rdata (rdata)
	);

	kss_deriv u_deriv (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (d_start),
		.sine       (rdata[31:16]),
		.cosine     (rdata[15:0]),
		.sum_sine   (sum_s_q),
		.sum_cosine (sum_c_q),
		.cos_lag    (cos_lag_q),
		.sin_lag    (sin_lag_q),
		.coupling   (coupling_q),
		.omega      (omega_q),
		.done       (d_done),
		.derivative (d_value)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			kss_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (!full) begin
						state_d = kss_pkg::ST_SC;
					end else if (in_data.last) begin
						state_d = kss_pkg::ST_RD;
					end
				end
			end
			kss_pkg::ST_SC: begin
				if (sc_done) begin
					state_d = last_q ? kss_pkg::ST_RD : kss_pkg::ST_IDLE;
				end
			end
			kss_pkg::ST_RD: state_d = kss_pkg::ST_ST;
			kss_pkg::ST_ST: state_d = kss_pkg::ST_DW;
			kss_pkg::ST_DW: begin
				if (d_done) begin
					state_d = kss_pkg::ST_EMIT;
				end
			end
			kss_pkg::ST_EMIT: begin
				if (out_acc) begin
					state_d = final_i ? kss_pkg::ST_IDLE : kss_pkg::ST_RD;
				end
			end
			default: state_d = kss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kss_pkg::ST_IDLE;
			omega_q    <= kss_pkg::RST_NATURAL_FREQUENCY;
			coupling_q <= kss_pkg::RST_COUPLING;
			cos_lag_q  <= kss_pkg::RST_COS_LAG;
			sin_lag_q  <= kss_pkg::RST_SIN_LAG;
			sum_s_q    <= '0;
			sum_c_q    <= '0;
			count_q    <= '0;
			i_q        <= '0;
			last_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					kss_pkg::REG_NATURAL_FREQUENCY: omega_q <= cfg_data;
					kss_pkg::REG_COUPLING: coupling_q <= cfg_data[15:0];
					kss_pkg::REG_COS_LAG: cos_lag_q <= cfg_data[15:0];
					kss_pkg::REG_SIN_LAG: sin_lag_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				last_q <= in_data.last;
			end
			if (sc_done) begin
				count_q <= count_q + CW'(1);
				// saturating sums
				if (ns_s > 23'(kss_pkg::SUM_HI)) sum_s_q <= kss_pkg::SUM_HI;
				else if (ns_s < 23'(kss_pkg::SUM_LO)) sum_s_q <= kss_pkg::SUM_LO;
				else sum_s_q <= 22'(ns_s);
				if (ns_c > 23'(kss_pkg::SUM_HI)) sum_c_q <= kss_pkg::SUM_HI;
				else if (ns_c < 23'(kss_pkg::SUM_LO)) sum_c_q <= kss_pkg::SUM_LO;
				else sum_c_q <= 22'(ns_c);
			end
			if (out_acc) begin
				if (final_i) begin
					i_q     <= '0;
					count_q <= '0;
					sum_s_q <= '0;
					sum_c_q <= '0;
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (d_done) begin
			out_q.derivative       <= d_value;
			out_q.oscillator_index <= idx_ext[5:0];
			out_q.last_result      <= final_i;
		end
	end

	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_q != '0)
		else $error("result shown with no oscillator loaded");

	a_sc_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> state_q == kss_pkg::ST_SC)
		else $error("sine unit finished outside load");

	a_deriv_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		d_done |-> state_q == kss_pkg::ST_DW)
		else $error("derivative finished outside wait");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_data.last_result) |=> (state_q == kss_pkg::ST_IDLE && count_q == '0))
		else $error("set not cleared after final result");

endmodule

// ===== tb/kss_checker.sv =====
// phase-rate predictor and result checker for the kuramoto-sakaguchi unit
`timescale 1ns / 1ps
module kss_checker #(
	parameter int MAX_OSCILLATORS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  kss_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  kss_pkg::out_item_t out_data,
	output int                 pending,
	output int                 fail_count
);

	logic signed [23:0] omega;
	logic signed [15:0] coupling;
	logic signed [15:0] lag_cos;
	logic signed [15:0] lag_sin;

	logic signed [15:0] sine_mem [MAX_OSCILLATORS];
	logic signed [15:0] cosine_mem [MAX_OSCILLATORS];
	longint sine_total;
	longint cosine_total;
	int osc_count;
	kss_pkg::out_item_t derivative_queue [$];

	assign pending = derivative_queue.size();

	// polynomial quarter-wave sine, quadrant folded
	function automatic longint wave_sine(logic [15:0] p);
		longint u, x, x2, t;
		u = p[14] ? 16384 - longint'(p[13:0]) : longint'(p[13:0]);
		x = 2 * u;
		x2 = (x * x) >>> 15;
		t = (longint'(kss_pkg::POLY_C) * x2) >>> 15;
		t = longint'(kss_pkg::POLY_B) - t;
		t = (t * x2) >>> 15;
		t = longint'(kss_pkg::POLY_A) - t;
		t = (t * x) >>> 15;
		if (t > 32767) t = 32767;
		return p[15] ? -t : t;
	endfunction

	// round to nearest, ties upward
	function automatic longint round_down(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		longint s, c, a, b, prod, d, v;
		logic [15:0] cp;
		int errs;
		kss_pkg::out_item_t got, want;
		if (!arst_n) begin
			omega <= kss_pkg::RST_NATURAL_FREQUENCY;
			coupling <= kss_pkg::RST_COUPLING;
			lag_cos <= kss_pkg::RST_COS_LAG;
			lag_sin <= kss_pkg::RST_SIN_LAG;
			sine_total = 0;
			cosine_total = 0;
			osc_count = 0;
			fail_count <= 0;
			derivative_queue.delete();
		end else begin
			errs = 0;
			if (cfg_write) begin
				case (kss_pkg::reg_index_t'(cfg_index))
					kss_pkg::REG_NATURAL_FREQUENCY: omega <= cfg_data;
					kss_pkg::REG_COUPLING:          coupling <= cfg_data[15:0];
					kss_pkg::REG_COS_LAG:           lag_cos <= cfg_data[15:0];
					kss_pkg::REG_SIN_LAG:           lag_sin <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = out_data;
				if (derivative_queue.size() == 0) begin
					$error("unexpected result: derivative %0d index %0d",
						got.derivative, got.oscillator_index);
					errs++;
				end else begin
					want = derivative_queue.pop_front();
					if (got.derivative !== want.derivative) begin
						$error("derivative: expected %0d, actual %0d",
							want.derivative, got.derivative);
						errs++;
					end
					if (got.oscillator_index !== want.oscillator_index) begin
						$error("oscillator_index: expected %0d, actual %0d",
							want.oscillator_index, got.oscillator_index);
						errs++;
					end
					if (got.last_result !== want.last_result) begin
						$error("last_result: expected %0d, actual %0d",
							want.last_result, got.last_result);
						errs++;
					end
				end
			end
			if (errs != 0) begin
				fail_count <= fail_count + errs;
			end
			if (in_valid && !in_stall) begin
				// a full store drops the phase but still honours last
				if (osc_count < MAX_OSCILLATORS) begin
					cp = in_data.phase + 16'd16384;
					s = wave_sine(in_data.phase);
					c = wave_sine(cp);
					sine_mem[osc_count] = 16'(s);
					cosine_mem[osc_count] = 16'(c);
					sine_total = clip(sine_total + s, longint'(kss_pkg::SUM_LO),
						longint'(kss_pkg::SUM_HI));
					cosine_total = clip(cosine_total + c, longint'(kss_pkg::SUM_LO),
						longint'(kss_pkg::SUM_HI));
					osc_count++;
				end
				if (in_data.last) begin
					for (int i = 0; i < osc_count; i++) begin
						s = longint'(sine_mem[i]);
						c = longint'(cosine_mem[i]);
						a = c * longint'(lag_cos) + s * longint'(lag_sin);
						b = s * longint'(lag_cos) - c * longint'(lag_sin);
						prod = sine_total * a - cosine_total * b;
						d = round_down(round_down(prod, 13) * longint'(coupling), 31);
						v = clip(longint'(omega) + d, longint'(kss_pkg::OUT_LO),
							longint'(kss_pkg::OUT_HI));
						want.derivative = v[23:0];
						want.oscillator_index = i[5:0];
						want.last_result = (i + 1 == osc_count);
						derivative_queue.push_back(want);
					end
					osc_count = 0;
					sine_total = 0;
					cosine_total = 0;
				end
			end
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the kuramoto-sakaguchi derivative unit
`timescale 1ns / 1ps
module tb_top;

	localparam int MAX_OSC_FILL = 66;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid;
	logic in_stall;
	kss_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	kss_pkg::out_item_t out_data;
	int pending;
	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;
	int sent;

	kuramoto_sakaguchi_derivative_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	kss_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.pending(pending), .fail_count(fail_count)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("kuramoto_sakaguchi_derivative_unit verification failed");
		$finish;
	end

	task automatic send_phase(input logic [15:0] p, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{phase: p, last: lst};
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++) send_phase(16'($urandom), i == n - 1);
	endtask

	// hold off until every derivative is out and the datapath has drained
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_regs(input logic [23:0] w, input logic [15:0] k,
		input logic [15:0] cl, input logic [15:0] sl);
		logic [23:0] vals [4];
		vals = '{w, {8'h0, k}, {8'h0, cl}, {8'h0, sl}};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [15:0] edge_phases [12];
		edge_phases = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001,
			16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'h5555, 16'hAAAA};
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = kss_pkg::REG_NATURAL_FREQUENCY;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		send_idle_pct = 36;
		recv_stall_pct = 52;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// quadrant edges with reset settings, then a single oscillator
		for (int i = 0; i < 12; i++) send_phase(edge_phases[i], i == 11);
		send_phase(16'h8000, 1'b1);
		drain();
		write_regs(24'h7FFFFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_set(4);
		drain();
		write_regs(24'h800000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_set(4);
		drain();

		// overfull set: the extra phases are dropped
		write_regs(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		send_set(MAX_OSC_FILL);
		drain();

		while (sent < 120) begin
			if (sent > 105) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else if (sent > 75) begin
				send_idle_pct = 52;
				recv_stall_pct = 36;
			end
			if ($urandom_range(3) == 0) begin
				drain();
				write_regs(24'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			end
			send_set($urandom_range(1, 8));
		end
		drain();

		if (fail_count == 0)
			$display("kuramoto_sakaguchi_derivative_unit verification clean");
		else
			$display("kuramoto_sakaguchi_derivative_unit verification failed");
		$finish;
	end

endmodule
